@@ hdl/fbpw_pkg.sv @@
// Package for the framebuffer pixel writer: beat payload types, pixel format
// and register index codes, and the luma constants. Depends on nothing.
`default_nettype none

package fbpw_pkg;

  localparam int COORD_W = 12;
  localparam int ADDR_W  = 19;
  localparam int SUM_W   = 18;

  // Luma divide by 1000 as a multiply by a rounded-up reciprocal of 2^28.
  localparam int LUMA_R_WEIGHT = 299;
  localparam int LUMA_G_WEIGHT = 587;
  localparam int LUMA_B_WEIGHT = 114;
  localparam int RECIP_W       = 19;
  localparam int LUMA_RECIP    = 268436;
  localparam int LUMA_SHIFT    = 28;
  localparam int PROD_W        = SUM_W + RECIP_W;
  localparam logic [7:0] MONO_THRESHOLD = 8'd127;

  typedef enum logic [2:0] {
    FMT_RGB888   = 3'd0,
    FMT_ARGB8888 = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_BGR565   = 3'd3,
    FMT_MONO01   = 3'd4,
    FMT_MONO10   = 3'd5,
    FMT_L8       = 3'd6,
    FMT_AL88     = 3'd7
  } pix_fmt_t;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_MONO_LAYOUT  = 3'd1,
    REG_CLIP_ENABLE  = 3'd2,
    REG_CLIP_LEFT    = 3'd3,
    REG_CLIP_TOP     = 3'd4,
    REG_CLIP_WIDTH   = 3'd5,
    REG_CLIP_HEIGHT  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [7:0]                alpha;
  } pixel_in_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] byte_address;
    logic [31:0]       write_bytes;
    logic [2:0]        num_bytes;
    logic [7:0]        bit_mask;
    logic              bit_value;
  } pixel_out_t;

  typedef struct packed {
    logic                      on_screen;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [7:0]                alpha;
    logic [SUM_W-1:0]          luma_sum;
  } stage1_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] lin_addr;
    logic [ADDR_W-1:0] mono_addr;
    logic [2:0]        mono_bit;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [7:0]        luma;
  } stage2_t;

endpackage

`default_nettype wire

@@ hdl/fbpw_chan_if.sv @@
// Valid/ready channel interface for the framebuffer pixel writer; the beat
// payload type is set where the channel is instantiated. Depends on nothing.
`default_nettype none

interface fbpw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/framebuffer_pixel_writer.sv @@
// Framebuffer pixel writer top level: a three-stage pipeline from a pixel beat
// to a framebuffer write beat. Uses fbpw_pkg and fbpw_chan_if.
//
// One pixel beat is accepted per clock unless the output stalls. The three
// register stages are screen test and luma weights, then clip test, luma
// divide and address multiply, then format packing into the output register.
// Stalls at the output back up through the stages without dropping or
// repeating beats. Rejected pixels still produce a beat with every field zero.
// Registers are written through cfg_we/cfg_index/cfg_data and must only
// change while the pipeline is empty.
`default_nettype none

module framebuffer_pixel_writer
  import fbpw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  fbpw_chan_if.sink        in_px,
  fbpw_chan_if.source      out_px
);

  localparam int MONO_ROW_BYTES = SCREEN_WIDTH / 8;

  // Configuration registers.
  pix_fmt_t                  pixel_format_r;
  logic [1:0]                mono_layout_r;
  logic                      clip_enable_r;
  logic signed [COORD_W-1:0] clip_left_r;
  logic signed [COORD_W-1:0] clip_top_r;
  logic [COORD_W-1:0]        clip_width_r;
  logic [COORD_W-1:0]        clip_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_RGB565;
      mono_layout_r  <= 2'd0;
      clip_enable_r  <= 1'b0;
      clip_left_r    <= '0;
      clip_top_r     <= '0;
      clip_width_r   <= 12'd320;
      clip_height_r  <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_PIXEL_FORMAT: pixel_format_r <= pix_fmt_t'(cfg_data[2:0]);
        REG_MONO_LAYOUT:  mono_layout_r  <= cfg_data[1:0];
        REG_CLIP_ENABLE:  clip_enable_r  <= cfg_data[0];
        REG_CLIP_LEFT:    clip_left_r    <= cfg_data;
        REG_CLIP_TOP:     clip_top_r     <= cfg_data;
        REG_CLIP_WIDTH:   clip_width_r   <= cfg_data;
        REG_CLIP_HEIGHT:  clip_height_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control.
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_r || out_px.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_px.ready = adv1;
  assign out_px.valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_px.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // Stage 1: screen bounds and luma weighted sum.
  pixel_in_t px;
  stage1_t   s1_nxt, s1_r;

  assign px = in_px.data;

  always_comb begin
    s1_nxt.on_screen = !px.pos_x[COORD_W-1] && !px.pos_y[COORD_W-1] &&
                       ({1'b0, px.pos_x} < (COORD_W+1)'(SCREEN_WIDTH)) &&
                       ({1'b0, px.pos_y} < (COORD_W+1)'(SCREEN_HEIGHT));
    s1_nxt.pos_x     = px.pos_x;
    s1_nxt.pos_y     = px.pos_y;
    s1_nxt.red       = px.red;
    s1_nxt.green     = px.green;
    s1_nxt.blue      = px.blue;
    s1_nxt.alpha     = px.alpha;
    s1_nxt.luma_sum  = SUM_W'(px.red)   * SUM_W'(LUMA_R_WEIGHT) +
                       SUM_W'(px.green) * SUM_W'(LUMA_G_WEIGHT) +
                       SUM_W'(px.blue)  * SUM_W'(LUMA_B_WEIGHT);
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_nxt;
  end

  // Stage 2: clip test, luma divide and address arithmetic.
  stage2_t            s2_nxt, s2_r;
  logic signed [13:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;
  logic               in_clip;
  logic [PROD_W-1:0]  luma_prod;
  logic [ADDR_W-1:0]  x_a, y_a;
  logic [2:0]         bit_sel;

  always_comb begin
    x_ext      = {{2{s1_r.pos_x[COORD_W-1]}}, s1_r.pos_x};
    y_ext      = {{2{s1_r.pos_y[COORD_W-1]}}, s1_r.pos_y};
    left_ext   = {{2{clip_left_r[COORD_W-1]}}, clip_left_r};
    top_ext    = {{2{clip_top_r[COORD_W-1]}}, clip_top_r};
    right_ext  = left_ext + $signed({2'b00, clip_width_r});
    bottom_ext = top_ext + $signed({2'b00, clip_height_r});
    in_clip    = (x_ext >= left_ext) && (y_ext >= top_ext) &&
                 (x_ext < right_ext) && (y_ext < bottom_ext);

    luma_prod  = PROD_W'(s1_r.luma_sum) * PROD_W'(LUMA_RECIP);

    x_a = ADDR_W'(s1_r.pos_x[COORD_W-2:0]);
    y_a = ADDR_W'(s1_r.pos_y[COORD_W-2:0]);

    s2_nxt.ok       = s1_r.on_screen && (!clip_enable_r || in_clip);
    s2_nxt.lin_addr = y_a * ADDR_W'(SCREEN_WIDTH) + x_a;
    if (mono_layout_r[0]) begin
      s2_nxt.mono_addr = x_a + (y_a >> 3) * ADDR_W'(SCREEN_WIDTH);
      bit_sel          = s1_r.pos_y[2:0];
    end else begin
      s2_nxt.mono_addr = (x_a >> 3) + y_a * ADDR_W'(MONO_ROW_BYTES);
      bit_sel          = s1_r.pos_x[2:0];
    end
    s2_nxt.mono_bit = mono_layout_r[1] ? (3'd7 - bit_sel) : bit_sel;
    s2_nxt.red      = s1_r.red;
    s2_nxt.green    = s1_r.green;
    s2_nxt.blue     = s1_r.blue;
    s2_nxt.alpha    = s1_r.alpha;
    s2_nxt.luma     = luma_prod[LUMA_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (adv2) s2_r <= s2_nxt;
  end

  // Stage 3: format packing into the output register.
  pixel_out_t        s3_nxt, s3_r;
  logic [15:0]       w565;
  logic [ADDR_W-1:0] lin2;

  always_comb begin
    w565   = {s2_r.red[7:3], s2_r.green[7:2], s2_r.blue[7:3]};
    lin2   = s2_r.lin_addr << 1;
    s3_nxt = '0;
    if (s2_r.ok) begin
      s3_nxt.write_enable = 1'b1;
      case (pixel_format_r)
        FMT_RGB888: begin
          s3_nxt.byte_address = s2_r.lin_addr + lin2;
          s3_nxt.write_bytes  = {8'h00, s2_r.blue, s2_r.green, s2_r.red};
          s3_nxt.num_bytes    = 3'd3;
        end
        FMT_ARGB8888: begin
          s3_nxt.byte_address = s2_r.lin_addr << 2;
          s3_nxt.write_bytes  = {s2_r.alpha, s2_r.red, s2_r.green, s2_r.blue};
          s3_nxt.num_bytes    = 3'd4;
        end
        FMT_RGB565: begin
          s3_nxt.byte_address = lin2;
          s3_nxt.write_bytes  = {16'h0000, w565[7:0], w565[15:8]};
          s3_nxt.num_bytes    = 3'd2;
        end
        FMT_BGR565: begin
          s3_nxt.byte_address = lin2;
          s3_nxt.write_bytes  = {16'h0000, w565};
          s3_nxt.num_bytes    = 3'd2;
        end
        FMT_L8: begin
          s3_nxt.byte_address = s2_r.lin_addr;
          s3_nxt.write_bytes  = {24'h000000, s2_r.luma};
          s3_nxt.num_bytes    = 3'd1;
        end
        FMT_AL88: begin
          s3_nxt.byte_address = lin2;
          s3_nxt.write_bytes  = {16'h0000, s2_r.alpha, s2_r.luma};
          s3_nxt.num_bytes    = 3'd2;
        end
        default: begin
          s3_nxt.byte_address = s2_r.mono_addr;
          s3_nxt.num_bytes    = 3'd1;
          s3_nxt.bit_mask     = 8'd1 << s2_r.mono_bit;
          s3_nxt.bit_value    = s2_r.luma > MONO_THRESHOLD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) s3_r <= s3_nxt;
  end

  assign out_px.data = s3_r;

endmodule

`default_nettype wire
